// ----- hdl/lpmd_pkg.sv -----
// Package for the length-prefixed marker deframer.
// Shared types, result codes and default sizes; no dependencies.
`timescale 1ns / 1ps

package lpmd_pkg;

	localparam int HEADER_BYTES     = 4;
	localparam int MARKER_BYTES_DEF = 4;
	localparam int CFG_IDX_W        = 2;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_BADLEN  = 2'd2;
	localparam logic [1:0] KIND_BADMARK = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_WORD = 2'd1;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1016;
	localparam logic [31:0] MARKER_WORD_RST = 32'd0;

	// Request held in the input register.
	typedef struct packed {
		logic       vld;
		logic [7:0] rx_byte;
	} lpmd_item_t;

	// Result produced by the parser for one request.
	typedef struct packed {
		logic       vld;
		logic [1:0] kind;
		logic [7:0] data;
	} lpmd_res_t;

endpackage

// ----- hdl/lpmd_in_stage.sv -----
// Input register of the deframer: takes one request per cycle while the result slot is free.
// Depends on lpmd_pkg.
`timescale 1ns / 1ps

module lpmd_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                go,
	output lpmd_pkg::lpmd_item_t item_s1
);

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       load;

	// Hold the request while the downstream slot is busy.
	assign in_stall = vld_s1 & ~go;
	assign load     = ~vld_s1 | go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	assign item_s1.vld     = vld_s1;
	assign item_s1.rx_byte = byte_s1;

endmodule

// ----- hdl/lpmd_parser.sv -----
// Frame parser: header, payload and marker phases, one byte per cycle while go is high.
// Depends on lpmd_pkg.
`timescale 1ns / 1ps

module lpmd_parser #(
	parameter int MARKER_BYTES = lpmd_pkg::MARKER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpmd_pkg::lpmd_item_t item_s1,
	input  logic                 go,
	input  logic [15:0]          max_payload,
	input  logic [31:0]          marker_word,
	output lpmd_pkg::lpmd_res_t  res
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_MARKER  = 2'd2;

	logic [1:0]  phase_q, phase_d;
	logic [15:0] pos_q, pos_d, pos_inc;
	logic [23:0] hdr_q, hdr_d;
	logic [15:0] len_q, len_d;
	logic        mism_q, mism_d, mism_nx;
	logic [1:0]  hpos;
	logic [7:0]  b, expect_byte;
	logic [31:0] hdr_word;
	logic        fire;

	assign b           = item_s1.rx_byte;
	assign fire        = item_s1.vld & go;
	assign pos_inc     = pos_q + 16'd1;
	assign expect_byte = marker_word[{pos_q[1:0], 3'b000} +: 8];
	assign mism_nx     = mism_q | (b != expect_byte);
	assign hdr_word    = {b, hdr_q};
	// Unused phase code restarts the header.
	assign hpos        = (phase_q == PH_HEADER) ? pos_q[1:0] : 2'd0;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		hdr_d    = hdr_q;
		len_d    = len_q;
		mism_d   = mism_q;
		res.vld  = 1'b0;
		res.kind = lpmd_pkg::KIND_DATA;
		res.data = 8'd0;
		case (phase_q)
			PH_PAYLOAD: begin
				pos_d    = pos_inc;
				res.vld  = 1'b1;
				res.data = b;
				if (pos_inc >= len_q) begin
					phase_d = PH_MARKER;
					pos_d   = 16'd0;
					mism_d  = 1'b0;
				end
			end
			PH_MARKER: begin
				pos_d  = pos_inc;
				mism_d = mism_nx;
				if (pos_inc >= 16'(MARKER_BYTES)) begin
					phase_d  = PH_HEADER;
					pos_d    = 16'd0;
					len_d    = 16'd0;
					mism_d   = 1'b0;
					res.vld  = 1'b1;
					res.kind = mism_nx ? lpmd_pkg::KIND_BADMARK : lpmd_pkg::KIND_GOOD;
				end
			end
			default: begin
				phase_d = PH_HEADER;
				if (phase_q != PH_HEADER) begin
					len_d  = 16'd0;
					mism_d = 1'b0;
				end
				case (hpos)
					2'd0: begin
						hdr_d[7:0] = b;
						pos_d      = 16'd1;
					end
					2'd1: begin
						hdr_d[15:8] = b;
						pos_d       = 16'd2;
					end
					2'd2: begin
						hdr_d[23:16] = b;
						pos_d        = 16'd3;
					end
					default: begin
						pos_d = 16'd0;
						if (b[7] || (hdr_word > {16'd0, max_payload})) begin
							len_d    = 16'd0;
							mism_d   = 1'b0;
							res.vld  = 1'b1;
							res.kind = lpmd_pkg::KIND_BADLEN;
						end else begin
							len_d  = hdr_q[15:0];
							mism_d = 1'b0;
							// Zero length goes straight to the marker.
							phase_d = (hdr_q[15:0] == 16'd0) ? PH_MARKER : PH_PAYLOAD;
						end
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 16'd0;
			hdr_q   <= 24'd0;
			len_q   <= 16'd0;
			mism_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			hdr_q   <= hdr_d;
			len_q   <= len_d;
			mism_q  <= mism_d;
		end
	end

`ifndef SYNTH
	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> pos_q < 16'(lpmd_pkg::HEADER_BYTES))
		else $error("header position out of range");
	a_mark_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MARKER |-> pos_q < 16'(MARKER_BYTES))
		else $error("marker position out of range");
	a_pay_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pos_q < len_q)
		else $error("payload position past frame length");
`endif

endmodule

// ----- hdl/lpmd_out_stage.sv -----
// Result register of the deframer, held while the receiver stalls.
// Depends on lpmd_pkg.
`timescale 1ns / 1ps

module lpmd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  lpmd_pkg::lpmd_res_t res,
	input  logic                fire,
	output logic                go,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          result_kind,
	output logic [7:0]          data_byte
);

	logic       vld_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;

	// Slot is free when empty or being taken this cycle.
	assign go = ~vld_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (go) begin
			vld_q <= fire & res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (go && fire && res.vld) begin
			kind_q <= res.kind;
			data_q <= res.data;
		end
	end

	assign out_valid   = vld_q;
	assign result_kind = kind_q;
	assign data_byte   = data_q;

endmodule

// ----- hdl/length_prefixed_marker_deframer.sv -----
// Length-prefixed frame deframer with end marker.
// Input channel (in_valid/in_stall/rx_byte): one received byte per request.
// Each frame: 4-byte little-endian signed length, payload, MARKER_BYTES marker.
// Output channel (out_valid/out_stall/result_kind/data_byte): one result per
// payload byte (kind 0), and one end result per frame: good, bad length
// (right after the header) or bad end marker (after all marker bytes).
// Header bytes (but the last of a bad length) and non-final marker bytes give no result.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
// max_payload, index 1 is marker_word; other indexes are ignored. cfg_ready
// is always high. Write only while the block is idle.
// The input register holds each accepted byte; the parser's result for it is
// registered in the result register once that slot is free.
// Throughput: one byte per cycle while the result slot is free; the parser state updates once per byte.
// Stall: while out_stall holds a result, one more byte waits in the input
// register, then in_stall rises.
// Reset: arst_n clears the valid bits of both register stages and returns the parser to the
// header phase; max_payload resets to 1016 and marker_word to zero.
`timescale 1ns / 1ps

module length_prefixed_marker_deframer #(
	parameter int MARKER_BYTES = lpmd_pkg::MARKER_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     result_kind,
	output logic [7:0]                     data_byte,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lpmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	lpmd_pkg::lpmd_item_t item_s1;
	lpmd_pkg::lpmd_res_t  res;
	logic                 go;
	logic [15:0]          max_payload_q;
	logic [31:0]          marker_word_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= lpmd_pkg::MAX_PAYLOAD_RST;
			marker_word_q <= lpmd_pkg::MARKER_WORD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lpmd_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_data[15:0];
				lpmd_pkg::REG_MARKER_WORD: marker_word_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lpmd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.go       (go),
		.item_s1  (item_s1)
	);

	lpmd_parser #(
		.MARKER_BYTES (MARKER_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_s1     (item_s1),
		.go          (go),
		.max_payload (max_payload_q),
		.marker_word (marker_word_q),
		.res         (res)
	);

	lpmd_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.fire        (item_s1.vld),
		.go          (go),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.data_byte   (data_byte)
	);

endmodule
